### rtl/linear_probe_hash_table_macros.svh
// Assertion macros shared by the checker files of the hash table block.
// Depends on nothing; include by bare file name.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPHT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lpht_pkg.sv
// Shared types and codes for the linear probing hash table.
// No dependencies; imported by the top level and its checker.
package lpht_pkg;

   localparam int KEY_W          = 31;
   localparam int OP_W           = 2;
   localparam int STATUS_W       = 2;
   localparam int SLOT_INDEX_W   = 4;
   localparam int TABLE_SIZE_DEF = 16;

   // home slot: key times a fixed-point reciprocal, then the remainder
   localparam int MOD_STEPS = 2;
   localparam int MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
   localparam int RECIP_W   = KEY_W + 1;
   localparam int PROD_W    = KEY_W + RECIP_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

   // slot marks
   localparam logic [1:0] SLOT_EMPTY    = 2'd0;
   localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
   localparam logic [1:0] SLOT_DELETED  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [SLOT_INDEX_W-1:0] slot_index;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       mark;
      logic [KEY_W-1:0] key;
   } slot_entry_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_RESP
   } lpht_state_type;

endpackage

### rtl/linear_probe_hash_table.sv
// Open-addressed hash table with linear probing, insert / remove / search.
// Depends on lpht_pkg; slot table is one internal synchronous memory.
//
//   channel  dir  handshake              beat
//   req      in   req_valid / req_stall  req_data  (op, key)
//   rsp      out  rsp_valid / rsp_stall  rsp_data  (status, slot_index)
//
// After reset a clearing pass marks every slot empty, with req_stall high.
// An item holds the block through P probes (1..TABLE_SIZE): it is taken in
// S_IDLE, finds the home slot in S_HASH (reciprocal multiply, then remainder),
// makes one memory read per probe in S_PROBE and posts the result in S_RESP.
// The single memory read port sets the probe rate. An unused op code goes
// from S_IDLE straight to S_RESP.
// rsp is a register: a stalled beat holds; the table keeps its answer in
// S_RESP until the output register frees up.
module linear_probe_hash_table #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lpht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpht_pkg::rsp_type rsp_data
);
   import lpht_pkg::*;

   localparam int SLOT_W  = $clog2(TABLE_SIZE);
   localparam int SHIFT_W = KEY_W + SLOT_W;
   // ceil(2^SHIFT_W / TABLE_SIZE); the quotient taken from it is exact for any key
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT_W) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

   // slot memory: mark and key together, one read and one write port
   slot_entry_type mem [TABLE_SIZE];

   lpht_state_type state_ff, state_in;

   logic [OP_W-1:0]      op_ff, op_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [MOD_CNT_W-1:0] mod_cnt_ff, mod_cnt_in;
   logic [SLOT_W-1:0]    pos_ff, pos_in;        // probe slot, also clear address
   logic [SLOT_W-1:0]    probe_cnt_ff, probe_cnt_in;
   rsp_type              res_ff, res_in;
   slot_entry_type       rd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 out_free;
   logic                 hash_last;
   logic                 pos_last;
   logic                 probe_last;
   logic [SLOT_W-1:0]    pos_inc;
   logic [SLOT_W-1:0]    quot_lo;
   logic [SLOT_W-1:0]    rem_next;
   logic [SLOT_W+3:0]    pos_wide;

   logic                 probe_done;
   logic                 probe_wr;
   slot_entry_type       probe_wr_data;
   rsp_type              probe_res;

   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_addr;
   slot_entry_type       wr_data;
   logic [SLOT_W-1:0]    rd_addr;
   logic                 rsp_load;

   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign hash_last  = (mod_cnt_ff == MOD_CNT_W'(MOD_STEPS - 1));
   assign pos_last   = (pos_ff == SLOT_W'(TABLE_SIZE - 1));
   assign probe_last = (probe_cnt_ff == SLOT_W'(TABLE_SIZE - 1));
   assign pos_inc    = pos_last ? '0 : pos_ff + SLOT_W'(1);
   assign pos_wide   = {4'b0000, pos_ff};

   // key mod TABLE_SIZE = key - quotient * TABLE_SIZE; the remainder is below
   // TABLE_SIZE, so the low SLOT_W bits of the difference are enough
   assign quot_lo  = prod_ff[SHIFT_W +: SLOT_W];
   assign rem_next = key_ff[SLOT_W-1:0] - quot_lo * SLOT_W'(TABLE_SIZE);

   // judge the slot whose entry sits in rd_data_ff (slot pos_ff)
   always_comb begin
      probe_done    = 1'b0;
      probe_wr      = 1'b0;
      probe_wr_data = rd_data_ff;
      probe_res     = '{status: ST_NOTFOUND, slot_index: '0};
      if (op_ff == OP_INSERT) begin
         if (rd_data_ff.mark != SLOT_OCCUPIED) begin
            probe_done    = 1'b1;
            probe_wr      = 1'b1;
            probe_wr_data = '{mark: SLOT_OCCUPIED, key: key_ff};
            probe_res     = '{status: ST_DONE, slot_index: pos_wide[3:0]};
         end else if (probe_last) begin
            probe_done = 1'b1;
            probe_res  = '{status: ST_FULL, slot_index: '0};
         end
      end else begin
         if (rd_data_ff.mark == SLOT_EMPTY) begin
            probe_done = 1'b1;
         end else if (rd_data_ff.mark == SLOT_OCCUPIED && rd_data_ff.key == key_ff) begin
            probe_done    = 1'b1;
            probe_wr      = (op_ff == OP_REMOVE);
            probe_wr_data = '{mark: SLOT_DELETED, key: rd_data_ff.key};
            probe_res     = '{status: ST_DONE, slot_index: pos_wide[3:0]};
         end else if (probe_last) begin
            probe_done = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (pos_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_data.op inside {OP_INSERT, OP_REMOVE, OP_SEARCH}) begin
                  state_in = S_HASH;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_HASH: begin
            if (hash_last) state_in = S_PROBE;
         end
         S_PROBE: begin
            if (probe_done) state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = probe_wr_data;
      rd_addr   = pos_inc;
      rsp_load  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '{mark: SLOT_EMPTY, key: '0};
         end
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_HASH: begin
            rd_addr = rem_next;   // home slot read, lands as the first probe
         end
         S_PROBE: begin
            wr_en = probe_done && probe_wr;
         end
         S_RESP: begin
            rsp_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      mod_cnt_in   = mod_cnt_ff;
      pos_in       = pos_ff;
      probe_cnt_in = probe_cnt_ff;
      res_in       = res_ff;
      // 31 x 32 bit product, valid in the cycle after key_ff settles
      prod_in      = PROD_W'(key_ff) * PROD_W'(RECIP);
      if (state_ff == S_CLEAR) begin
         pos_in = pos_inc;
      end
      if (accept) begin
         op_in      = req_data.op;
         key_in     = req_data.key;
         mod_cnt_in = '0;
         res_in     = '{status: ST_NOTFOUND, slot_index: '0};
      end
      if (state_ff == S_HASH) begin
         mod_cnt_in = mod_cnt_ff + MOD_CNT_W'(1);
         if (hash_last) begin
            pos_in       = rem_next;
            probe_cnt_in = '0;
         end
      end
      if (state_ff == S_PROBE) begin
         if (probe_done) begin
            res_in = probe_res;
         end else begin
            pos_in       = pos_inc;
            probe_cnt_in = probe_cnt_ff + SLOT_W'(1);
         end
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_load ? res_ff : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      prod_ff      <= prod_in;
      mod_cnt_ff   <= mod_cnt_in;
      probe_cnt_ff <= probe_cnt_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // slot memory, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/lpht_checker.sv
// Port-level checks for the hash table top level, attached by bind.
// Depends on lpht_pkg and linear_probe_hash_table_macros.svh.
`include "linear_probe_hash_table_macros.svh"

module lpht_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input lpht_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lpht_pkg::rsp_type rsp_data
);
   import lpht_pkg::*;

   logic req_beat;
   logic rsp_held;

   assign req_beat = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;

   `LPHT_ASSERT_NEXT(a_rsp_valid_held, clock, reset, rsp_held, rsp_valid, "rsp beat dropped")
   `LPHT_ASSERT_NEXT(a_rsp_data_held, clock, reset, rsp_held, $stable(rsp_data), "rsp data moved")
   `LPHT_ASSERT_IMPLY(a_miss_slot_zero, clock, reset, rsp_valid && rsp_data.status != ST_DONE, rsp_data.slot_index == '0, "miss with slot")
   `LPHT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, req_stall, "req taken twice")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### tb/linear_probe_hash_table_check.sv
// Checker for the linear probing hash table: watches the request and answer
// channels, keeps its own copy of the slot store and compares answer beats.
// Depends on lpht_pkg.
module linear_probe_hash_table_check #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  lpht_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  lpht_pkg::rsp_type rsp_data,
   output int                failures,
   output int                pending
);
   import lpht_pkg::*;

   logic [1:0]       slot_marks [TABLE_SIZE];
   logic [KEY_W-1:0] slot_keys  [TABLE_SIZE];
   rsp_type          expected_answers [$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   task automatic report_mismatch(input string what);
      if (failures < 50) $display("MISMATCH at %0t: %s", $time, what);
      failures++;
   endtask

   // Applies one request to the shadow table and returns the answer it earns.
   function automatic rsp_type table_answer(input req_type item);
      rsp_type ans;
      int      pos;
      int      n;
      bit      done;
      ans.status     = ST_NOTFOUND;
      ans.slot_index = '0;
      pos            = int'(item.key % TABLE_SIZE);
      done           = 1'b0;
      case (item.op)
         OP_INSERT: begin
            // first empty or deleted slot wins; duplicates are not checked
            ans.status = ST_FULL;
            for (n = 0; n < TABLE_SIZE && !done; n++) begin
               if (slot_marks[pos] != SLOT_OCCUPIED) begin
                  slot_marks[pos] = SLOT_OCCUPIED;
                  slot_keys[pos]  = item.key;
                  ans.status      = ST_DONE;
                  ans.slot_index  = pos[SLOT_INDEX_W-1:0];
                  done            = 1'b1;
               end else begin
                  pos = (pos + 1) % TABLE_SIZE;
               end
            end
         end
         OP_REMOVE, OP_SEARCH: begin
            // deleted slots are passed over, an empty one ends the chain
            for (n = 0; n < TABLE_SIZE && !done; n++) begin
               if (slot_marks[pos] == SLOT_EMPTY) begin
                  done = 1'b1;
               end else if (slot_marks[pos] == SLOT_OCCUPIED && slot_keys[pos] == item.key) begin
                  if (item.op == OP_REMOVE) slot_marks[pos] = SLOT_DELETED;
                  ans.status     = ST_DONE;
                  ans.slot_index = pos[SLOT_INDEX_W-1:0];
                  done           = 1'b1;
               end else begin
                  pos = (pos + 1) % TABLE_SIZE;
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) slot_marks[i] = SLOT_EMPTY;
         expected_answers.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = rsp_data;
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("answer beat (status %0d, slot %0d) with no request",
                                         got.status, got.slot_index));
            end else begin
               want = expected_answers.pop_front();
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
               if (got.slot_index !== want.slot_index)
                  report_mismatch($sformatf("slot_index %0d, expected %0d",
                                            got.slot_index, want.slot_index));
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            expected_answers.push_back(table_answer(req_data));
      end
      pending <= expected_answers.size();
   end

endmodule

### tb/linear_probe_hash_table_test.sv
// Top of the hash table testbench: clock, reset, request and answer traffic.
// Depends on lpht_pkg, linear_probe_hash_table and linear_probe_hash_table_check.
module linear_probe_hash_table_test;
   import lpht_pkg::*;

   localparam int TABLE_SIZE   = TABLE_SIZE_DEF;
   localparam int RANDOM_ITEMS = 1825;
   localparam int POOL_SIZE    = 32;
   // worst item plus margin; leave plenty of room after the last beat
   localparam int DRAIN_CYCLES = 3 * (4 + TABLE_SIZE);
   // budget for ~1850 items plus two long hold-offs, with a wide margin
   localparam int CYCLE_LIMIT  = 500000;
   localparam int HOLD_CYCLES  = 300;

   // op code 3 is unused by the block: no change, answered as not found
   localparam logic [OP_W-1:0]  OP_RESERVED = 2'd3;
   localparam logic [KEY_W-1:0] KEY_MAX     = {KEY_W{1'b1}};

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      cycle_count = 0;

   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   linear_probe_hash_table #(.TABLE_SIZE(TABLE_SIZE)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   linear_probe_hash_table_check #(.TABLE_SIZE(TABLE_SIZE)) table_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_type make_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      req_type item;
      item.op  = op;
      item.key = key;
      return item;
   endfunction

   // Sends one request beat after a random gap (none in a steady stretch).
   // Valid and data are only touched once the previous beat has gone, so a
   // stalled beat never changes.
   task automatic offer(input req_type item, input bit steady);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Request side: directed opening, then random traffic, then the verdict.
   initial begin : req_side
      req_type item;
      int      i;
      int      op_roll;
      int      insert_pct;
      bit      steady;

      // keys are random over all 31 bits; half of them crowd onto a few home
      // slots so that probe chains get long and collide
      for (i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = KEY_W'($urandom);
         if (i % 2 == 0) key_pool[i][3:0] = 4'($urandom_range(0, 5));
      end
      steady     = 1'b0;
      insert_pct = 40;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // misses on an empty table, and the unused op code
      offer(make_req(OP_SEARCH, '0), steady);
      offer(make_req(OP_REMOVE, KEY_MAX), steady);
      offer(make_req(OP_RESERVED, KEY_MAX), steady);
      // every key below has home slot TABLE_SIZE-1 (KEY_MAX too, since the
      // table size is a power of two), so the chain wraps to slot 0 and fills
      // the whole table
      for (i = 0; i < TABLE_SIZE - 1; i++)
         offer(make_req(OP_INSERT, KEY_W'(TABLE_SIZE - 1 + TABLE_SIZE * i)), steady);
      offer(make_req(OP_INSERT, KEY_MAX), steady);
      // table full; absent key probes a full circle of occupied slots
      offer(make_req(OP_INSERT, '0), steady);
      offer(make_req(OP_SEARCH, KEY_W'(TABLE_SIZE - 1 + TABLE_SIZE * 20)), steady);
      // remove from the middle of the chain, then search past the deleted mark
      offer(make_req(OP_REMOVE, KEY_W'(TABLE_SIZE - 1 + TABLE_SIZE * 3)), steady);
      offer(make_req(OP_SEARCH, KEY_MAX), steady);
      // insert reuses the deleted slot; the removed key now misses
      offer(make_req(OP_INSERT, '0), steady);
      offer(make_req(OP_SEARCH, KEY_W'(TABLE_SIZE - 1 + TABLE_SIZE * 3)), steady);

      // random traffic; the insert share swings between phases so the table
      // both drains toward empty and packs up to full
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         if (i % 100 == 0) insert_pct = 20 * $urandom_range(1, 3);
         op_roll  = $urandom_range(0, 99);
         item.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (op_roll < 4)
            item.op = OP_RESERVED;
         else if (op_roll < 4 + insert_pct)
            item.op = OP_INSERT;
         else if (op_roll < 4 + insert_pct + (96 - insert_pct) / 2)
            item.op = OP_REMOVE;
         else
            item.op = OP_SEARCH;
         // now and then look for a key that was most likely never stored
         if (item.op != OP_INSERT && $urandom_range(0, 6) == 0) item.key = KEY_W'($urandom);
         offer(item, steady);
      end
      req_valid <= 1'b0;

      // pending is registered in the checker, so it already counts the last beat
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("linear_probe_hash_table_test OK");
      else
         $display("linear_probe_hash_table_test NOT OK");
      $finish;
   end

   // Answer side: random stall before each beat, steady stretches without
   // stalls, and two long hold-offs that back the block up into req_stall.
   initial begin : rsp_side
      int wait_cycles;
      int beats_taken;
      bit steady;
      beats_taken = 0;
      steady      = 1'b0;
      @(posedge clock);
      forever begin
         if (beats_taken % 40 == 0) steady = ($urandom_range(0, 2) == 0);
         wait_cycles = steady ? 0 : $urandom_range(0, 13);
         if (beats_taken == 400 || beats_taken == 1200) wait_cycles = HOLD_CYCLES;
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         beats_taken++;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("linear_probe_hash_table_test NOT OK");
      $finish;
   end

endmodule

### linear_probe_hash_table.f
+incdir+rtl
rtl/lpht_pkg.sv
rtl/linear_probe_hash_table.sv
rtl/lpht_checker.sv
tb/linear_probe_hash_table_check.sv
tb/linear_probe_hash_table_test.sv
